### rtl/core/sot_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths, mode codes and helper functions for the shape overlap test.
// Used by every module of the block; depends on nothing.
package sot_pkg;

  localparam int COORD_BITS = 16;
  localparam int SIZE_BITS  = COORD_BITS - 1;
  localparam int WIDE_BITS  = COORD_BITS + 2;
  localparam int MAG_BITS   = COORD_BITS + 1;
  localparam int SQ_BITS    = 2 * MAG_BITS;
  localparam int SUM_BITS   = SQ_BITS + 1;

  localparam logic [2:0] MODE_RECT_RECT        = 3'd0;
  localparam logic [2:0] MODE_RECT_CIRCLE      = 3'd1;
  localparam logic [2:0] MODE_CIRCLE_CIRCLE    = 3'd2;
  localparam logic [2:0] MODE_RECT_IN_RECT     = 3'd3;
  localparam logic [2:0] MODE_RECT_IN_CIRCLE   = 3'd4;
  localparam logic [2:0] MODE_CIRCLE_IN_RECT   = 3'd5;
  localparam logic [2:0] MODE_CIRCLE_IN_CIRCLE = 3'd6;

  typedef logic signed [WIDE_BITS-1:0] wide_t;
  typedef logic [MAG_BITS-1:0]         mag_t;
  typedef logic [SQ_BITS-1:0]          sq_t;
  typedef logic [SUM_BITS-1:0]         sum_t;

  typedef struct packed {
    logic [2:0]                   mode;
    logic                         strict;
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic [SIZE_BITS-1:0]         a_w;
    logic [SIZE_BITS-1:0]         a_h;
    logic [SIZE_BITS-1:0]         a_r;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic [SIZE_BITS-1:0]         b_w;
    logic [SIZE_BITS-1:0]         b_h;
    logic [SIZE_BITS-1:0]         b_r;
  } in_t;

  typedef struct packed {
    logic hit;
    logic bad_mode;
  } out_t;

  // control bits that ride along with the distance operands
  typedef struct packed {
    logic use_dist;
    logic gate_ok;
    logic strict;
    logic direct_hit;
    logic bad_mode;
  } flags_t;

  typedef struct packed {
    flags_t flags;
    mag_t   dx;
    mag_t   dy;
    mag_t   lim;
  } setup_t;

  typedef struct packed {
    flags_t flags;
    sq_t    dx_sq;
    sq_t    dy_sq;
    sq_t    lim_sq;
  } dist_t;

  function automatic wide_t coord_ext(input logic [COORD_BITS-1:0] v);
    return {{(WIDE_BITS-COORD_BITS){v[COORD_BITS-1]}}, v};
  endfunction

  function automatic wide_t size_ext(input logic [SIZE_BITS-1:0] v);
    return {{(WIDE_BITS-SIZE_BITS){1'b0}}, v};
  endfunction

  function automatic mag_t abs_mag(input wide_t d);
    wide_t n;
    n = d[WIDE_BITS-1] ? -d : d;
    return n[MAG_BITS-1:0];
  endfunction

  function automatic logic le_lt(input wide_t p, input wide_t q, input logic st);
    return st ? (p < q) : (p <= q);
  endfunction

endpackage

### rtl/core/sot_setup.sv
`timescale 1ns / 1ps
// Operand setup: edge sums, region select, direct comparisons and distance operands.
// Depends on sot_pkg.
module sot_setup (
  input  sot_pkg::in_t    item,
  output sot_pkg::setup_t setup
);

  sot_pkg::wide_t ax, ay, aw, ah, ar, bx, by, bw, bh, br;
  sot_pkg::wide_t a_right, a_bot, lim;
  sot_pkg::mag_t  mx0, mx1, my0, my1, dx_mag, dy_mag, lim_mag;
  logic           left, right, above, below, st;
  logic           use_dist, dist_strict, direct, bad, gate;

  always_comb begin
    ax = sot_pkg::coord_ext(item.a_x);
    ay = sot_pkg::coord_ext(item.a_y);
    aw = sot_pkg::size_ext(item.a_w);
    ah = sot_pkg::size_ext(item.a_h);
    ar = sot_pkg::size_ext(item.a_r);
    bx = sot_pkg::coord_ext(item.b_x);
    by = sot_pkg::coord_ext(item.b_y);
    bw = sot_pkg::size_ext(item.b_w);
    bh = sot_pkg::size_ext(item.b_h);
    br = sot_pkg::size_ext(item.b_r);
    st = item.strict;

    a_right = ax + aw;
    a_bot   = ay + ah;
    left    = bx < ax;
    right   = bx > a_right;
    above   = by < ay;
    below   = by > a_bot;

    // distances from b to each x edge and each y edge of a
    mx0 = sot_pkg::abs_mag(ax - bx);
    mx1 = sot_pkg::abs_mag(a_right - bx);
    my0 = sot_pkg::abs_mag(ay - by);
    my1 = sot_pkg::abs_mag(a_bot - by);

    use_dist    = 1'b0;
    dist_strict = 1'b0;
    direct      = 1'b0;
    bad         = 1'b0;
    dx_mag      = mx0;
    dy_mag      = my0;
    lim         = ar + br;

    unique case (item.mode)
      sot_pkg::MODE_RECT_RECT: begin
        direct = sot_pkg::le_lt(bx, a_right, st) && sot_pkg::le_lt(ax, bx + bw, st) &&
                 sot_pkg::le_lt(by, a_bot, st) && sot_pkg::le_lt(ay, by + bh, st);
      end
      sot_pkg::MODE_RECT_CIRCLE: begin
        if ((left || right) && (above || below)) begin
          // centre in a corner region: distance to that corner
          use_dist    = 1'b1;
          dist_strict = st;
          dx_mag      = left ? mx0 : mx1;
          dy_mag      = above ? my0 : my1;
          lim         = br;
        end else begin
          direct = sot_pkg::le_lt(ax, bx + br, st) && sot_pkg::le_lt(bx - br, a_right, st) &&
                   sot_pkg::le_lt(ay, by + br, st) && sot_pkg::le_lt(by - br, a_bot, st);
        end
      end
      sot_pkg::MODE_CIRCLE_CIRCLE: begin
        use_dist    = 1'b1;
        dist_strict = st;
        lim         = ar + br;
      end
      sot_pkg::MODE_RECT_IN_RECT: begin
        direct = (ax >= bx) && (a_right <= bx + bw) && (ay >= by) && (a_bot <= by + bh);
      end
      sot_pkg::MODE_RECT_IN_CIRCLE: begin
        // all four corners inside iff the farthest corner is inside
        use_dist = 1'b1;
        dx_mag   = (mx0 > mx1) ? mx0 : mx1;
        dy_mag   = (my0 > my1) ? my0 : my1;
        lim      = br;
      end
      sot_pkg::MODE_CIRCLE_IN_RECT: begin
        direct = (ax - ar >= bx) && (ax + ar <= bx + bw) &&
                 (ay - ar >= by) && (ay + ar <= by + bh);
      end
      sot_pkg::MODE_CIRCLE_IN_CIRCLE: begin
        use_dist = 1'b1;
        lim      = br - ar;
      end
      default: begin
        bad = 1'b1;
      end
    endcase

    lim_mag = lim[sot_pkg::MAG_BITS-1:0];
    gate    = dist_strict ? (dx_mag < lim_mag && dy_mag < lim_mag)
                          : (dx_mag <= lim_mag && dy_mag <= lim_mag);

    setup.flags.use_dist   = use_dist;
    setup.flags.gate_ok    = !lim[sot_pkg::WIDE_BITS-1] && gate;
    setup.flags.strict     = dist_strict;
    setup.flags.direct_hit = direct;
    setup.flags.bad_mode   = bad;
    setup.dx               = dx_mag;
    setup.dy               = dy_mag;
    setup.lim              = lim_mag;
  end

endmodule

### rtl/core/sot_square.sv
`timescale 1ns / 1ps
// Squares of the two axis distances and of the limit, computed in parallel.
// Depends on sot_pkg.
module sot_square (
  input  sot_pkg::setup_t setup,
  output sot_pkg::dist_t  squares
);

  always_comb begin
    squares.flags  = setup.flags;
    squares.dx_sq  = sot_pkg::sq_t'(setup.dx) * sot_pkg::sq_t'(setup.dx);
    squares.dy_sq  = sot_pkg::sq_t'(setup.dy) * sot_pkg::sq_t'(setup.dy);
    squares.lim_sq = sot_pkg::sq_t'(setup.lim) * sot_pkg::sq_t'(setup.lim);
  end

endmodule

### rtl/core/sot_decide.sv
`timescale 1ns / 1ps
// Final decision: squared distance sum against squared limit, or the direct test.
// Depends on sot_pkg.
module sot_decide (
  input  sot_pkg::dist_t squares,
  output sot_pkg::out_t  result
);

  sot_pkg::sum_t sum;
  sot_pkg::sum_t lim_sq;
  logic          reach_ok;

  always_comb begin
    sum      = sot_pkg::sum_t'(squares.dx_sq) + sot_pkg::sum_t'(squares.dy_sq);
    lim_sq   = sot_pkg::sum_t'(squares.lim_sq);
    reach_ok = squares.flags.gate_ok &&
               (squares.flags.strict ? (sum < lim_sq) : (sum <= lim_sq));

    result.bad_mode = squares.flags.bad_mode;
    result.hit      = !squares.flags.bad_mode &&
                      (squares.flags.use_dist ? reach_ok : squares.flags.direct_hit);
  end

endmodule

### rtl/core/shape_overlap_test_unit.sv
`timescale 1ns / 1ps
// Shape overlap test: three-register pipeline (input, squares, result).
// Depends on sot_pkg and the sot_setup, sot_square and sot_decide stages.
// An accepted item passes through the input, squares and result registers in turn before it is on out_data.
// Throughput: one item per cycle while out_ready allows; each stage moves whenever the one after it is free,
// so an out_ready stall backs up only as far as the stages that are full.
// Reset (rst, synchronous) clears the stage valid bits only; payload is not reset.
module shape_overlap_test_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sot_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output sot_pkg::out_t out_data
);

  logic            s0_valid;
  sot_pkg::in_t    s0_data;
  logic            s1_valid;
  sot_pkg::dist_t  s1_data;
  sot_pkg::setup_t setup;
  sot_pkg::dist_t  dist_next;
  sot_pkg::out_t   result_next;
  logic            out_adv, s1_adv, s0_adv;

  sot_setup u_setup (
    .item  (s0_data),
    .setup (setup)
  );

  sot_square u_square (
    .setup   (setup),
    .squares (dist_next)
  );

  sot_decide u_decide (
    .squares (s1_data),
    .result  (result_next)
  );

  assign out_adv  = !out_valid || out_ready;
  assign s1_adv   = !s1_valid || out_adv;
  assign s0_adv   = !s0_valid || s1_adv;
  assign in_ready = s0_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s0_adv) begin
        s0_valid <= in_valid;
      end
      if (s1_adv) begin
        s1_valid <= s0_valid;
      end
      if (out_adv) begin
        out_valid <= s1_valid;
      end
    end
  end

  // payload moves with its valid bit; hold while the next stage is full
  always_ff @(posedge clk) begin
    if (s0_adv && in_valid) begin
      s0_data <= in_data;
    end
    if (s1_adv && s0_valid) begin
      s1_data <= dist_next;
    end
    if (out_adv && s1_valid) begin
      out_data <= result_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.hit && out_data.bad_mode))
    else $error("hit set together with bad_mode");

  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> s0_valid)
    else $error("accepted transfer did not enter the input stage");

  assert property (@(posedge clk) disable iff (rst)
    s0_valid && s1_adv |=> s1_valid &&
      (s1_data.flags.bad_mode == ($past(s0_data.mode) > sot_pkg::MODE_CIRCLE_IN_CIRCLE)))
    else $error("bad_mode does not follow the mode code");

  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_adv |=> s1_valid && $stable(s1_data))
    else $error("middle stage dropped or changed an item during a stall");

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// Testbench for shape_overlap_test_unit: directed edge cases, then random shape pairs
// under shifting sender and receiver stalls, each result checked against a hit predictor.
// Depends on sot_pkg and the unit's RTL only.
module tb;

  localparam int         COORD_BITS     = sot_pkg::COORD_BITS;
  localparam int         SIZE_BITS      = sot_pkg::SIZE_BITS;
  localparam logic [2:0] MODE_UNDEFINED = 3'd7;

  class overlap_scoreboard;
    sot_pkg::out_t awaited_verdicts[$];
    int            mismatches;

    function new();
      mismatches = 0;
    endfunction

    // (dx,dy) lies within lim of the origin; box gate first, then squared distance
    function bit within_reach(longint dx, longint dy, longint lim, bit st);
      longint mx, my, dist_sq, lim_sq;
      if (lim < 0) return 1'b0;
      mx = (dx < 0) ? -dx : dx;
      my = (dy < 0) ? -dy : dy;
      if (st ? (mx >= lim || my >= lim) : (mx > lim || my > lim)) return 1'b0;
      dist_sq = mx * mx + my * my;
      lim_sq  = lim * lim;
      return st ? (dist_sq < lim_sq) : (dist_sq <= lim_sq);
    endfunction

    function bit edge_ok(longint p, longint q, bit st);
      return st ? (p < q) : (p <= q);
    endfunction

    function sot_pkg::out_t predict_verdict(sot_pkg::in_t d);
      sot_pkg::out_t v;
      bit            st;
      longint        ax, ay, aw, ah, ar, bx, by, bw, bh, br, a_right, a_top;
      st = d.strict;
      ax = longint'($signed(d.a_x));
      ay = longint'($signed(d.a_y));
      bx = longint'($signed(d.b_x));
      by = longint'($signed(d.b_y));
      aw = longint'(d.a_w);
      ah = longint'(d.a_h);
      ar = longint'(d.a_r);
      bw = longint'(d.b_w);
      bh = longint'(d.b_h);
      br = longint'(d.b_r);
      a_right = ax + aw;
      a_top   = ay + ah;
      v = '0;
      case (d.mode)
        sot_pkg::MODE_RECT_RECT: begin
          v.hit = edge_ok(bx, a_right, st) && edge_ok(ax, bx + bw, st) &&
                  edge_ok(by, a_top, st) && edge_ok(ay, by + bh, st);
        end
        sot_pkg::MODE_RECT_CIRCLE: begin
          // corner regions test the distance to that corner
          if (bx < ax && by < ay) begin
            v.hit = within_reach(bx - ax, by - ay, br, st);
          end else if (bx > a_right && by < ay) begin
            v.hit = within_reach(bx - a_right, by - ay, br, st);
          end else if (bx < ax && by > a_top) begin
            v.hit = within_reach(bx - ax, by - a_top, br, st);
          end else if (bx > a_right && by > a_top) begin
            v.hit = within_reach(bx - a_right, by - a_top, br, st);
          end else begin
            v.hit = edge_ok(ax, bx + br, st) && edge_ok(bx - br, a_right, st) &&
                    edge_ok(ay, by + br, st) && edge_ok(by - br, a_top, st);
          end
        end
        sot_pkg::MODE_CIRCLE_CIRCLE: begin
          v.hit = within_reach(ax - bx, ay - by, ar + br, st);
        end
        sot_pkg::MODE_RECT_IN_RECT: begin
          v.hit = ax >= bx && a_right <= bx + bw && ay >= by && a_top <= by + bh;
        end
        sot_pkg::MODE_RECT_IN_CIRCLE: begin
          v.hit = within_reach(ax - bx, ay - by, br, 1'b0) &&
                  within_reach(ax - bx, a_top - by, br, 1'b0) &&
                  within_reach(a_right - bx, ay - by, br, 1'b0) &&
                  within_reach(a_right - bx, a_top - by, br, 1'b0);
        end
        sot_pkg::MODE_CIRCLE_IN_RECT: begin
          v.hit = ax - ar >= bx && ax + ar <= bx + bw &&
                  ay - ar >= by && ay + ar <= by + bh;
        end
        sot_pkg::MODE_CIRCLE_IN_CIRCLE: begin
          v.hit = within_reach(ax - bx, ay - by, br - ar, 1'b0);
        end
        default: begin
          v.bad_mode = 1'b1;
        end
      endcase
      return v;
    endfunction

    function void note_request(sot_pkg::in_t d);
      awaited_verdicts.push_back(predict_verdict(d));
    endfunction

    function void check_verdict(sot_pkg::out_t got);
      sot_pkg::out_t want;
      if (awaited_verdicts.size() == 0) begin
        $display("%0t: unexpected result: expected none, got hit=%0b bad_mode=%0b",
                 $time, got.hit, got.bad_mode);
        mismatches++;
        return;
      end
      want = awaited_verdicts.pop_front();
      if (got.hit !== want.hit) begin
        $display("%0t: hit mismatch: expected %0b, got %0b", $time, want.hit, got.hit);
        mismatches++;
      end
      if (got.bad_mode !== want.bad_mode) begin
        $display("%0t: bad_mode mismatch: expected %0b, got %0b",
                 $time, want.bad_mode, got.bad_mode);
        mismatches++;
      end
    endfunction
  endclass

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          in_valid  = 1'b0;
  logic          in_ready;
  sot_pkg::in_t  in_data   = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  sot_pkg::out_t out_data;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  overlap_scoreboard verdicts;

  shape_overlap_test_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= (int'($urandom_range(0, 99)) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) verdicts.check_verdict(out_data);
  end

  function automatic sot_pkg::in_t shape_pair(logic [2:0] m, bit st,
                                              int ax, int ay, int aw, int ah, int ar,
                                              int bx, int by, int bw, int bh, int br);
    sot_pkg::in_t d;
    d.mode   = m;
    d.strict = st;
    d.a_x    = COORD_BITS'(ax);
    d.a_y    = COORD_BITS'(ay);
    d.a_w    = SIZE_BITS'(aw);
    d.a_h    = SIZE_BITS'(ah);
    d.a_r    = SIZE_BITS'(ar);
    d.b_x    = COORD_BITS'(bx);
    d.b_y    = COORD_BITS'(by);
    d.b_w    = SIZE_BITS'(bw);
    d.b_h    = SIZE_BITS'(bh);
    d.b_r    = SIZE_BITS'(br);
    return d;
  endfunction

  function automatic int spread(int span, int step);
    return (int'($urandom_range(0, 2 * span)) - span) * step;
  endfunction

  function automatic int extent(int span, int step);
    return int'($urandom_range(0, span)) * step;
  endfunction

  // a quarter full-range noise, the rest shapes clustered near a shared origin;
  // the coarse grid makes touching edges and equal distances common
  function automatic sot_pkg::in_t random_pair();
    sot_pkg::in_t d;
    int           pick, step, span, grow, ox, oy;
    pick     = int'($urandom_range(0, 15));
    d.mode   = (pick == 15) ? MODE_UNDEFINED : 3'(pick % 7);
    d.strict = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 3) == 0) begin
      d.a_x = COORD_BITS'($urandom);
      d.a_y = COORD_BITS'($urandom);
      d.a_w = SIZE_BITS'($urandom);
      d.a_h = SIZE_BITS'($urandom);
      d.a_r = SIZE_BITS'($urandom);
      d.b_x = COORD_BITS'($urandom);
      d.b_y = COORD_BITS'($urandom);
      d.b_w = SIZE_BITS'($urandom);
      d.b_h = SIZE_BITS'($urandom);
      d.b_r = SIZE_BITS'($urandom);
    end else begin
      step = ($urandom_range(0, 1) == 1) ? 64 : 1;
      span = (step == 64) ? 8 : 600;
      grow = (d.mode >= sot_pkg::MODE_RECT_IN_RECT) ? 3 : 1;
      ox   = int'($urandom_range(0, 40000)) - 20000;
      oy   = int'($urandom_range(0, 40000)) - 20000;
      d.a_x = COORD_BITS'(ox + spread(span, step));
      d.a_y = COORD_BITS'(oy + spread(span, step));
      d.a_w = SIZE_BITS'(extent(span, step));
      d.a_h = SIZE_BITS'(extent(span, step));
      d.a_r = SIZE_BITS'(extent(span, step));
      d.b_w = SIZE_BITS'(extent(grow * span, step));
      d.b_h = SIZE_BITS'(extent(grow * span, step));
      d.b_r = SIZE_BITS'(extent(grow * span, step));
      // place a container corner above and left of the shared origin so containment can hold
      if (d.mode == sot_pkg::MODE_RECT_IN_RECT || d.mode == sot_pkg::MODE_CIRCLE_IN_RECT) begin
        d.b_x = COORD_BITS'(ox - extent(2 * span, step));
        d.b_y = COORD_BITS'(oy - extent(2 * span, step));
      end else begin
        d.b_x = COORD_BITS'(ox + spread(span, step));
        d.b_y = COORD_BITS'(oy + spread(span, step));
      end
    end
    return d;
  endfunction

  // call just after a falling edge; returns just after the falling edge past the transfer
  task automatic send_shapes(input sot_pkg::in_t d);
    while (int'($urandom_range(0, 99)) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    verdicts.note_request(d);
    @(negedge clk);
  endtask

  task automatic run_phase(input int snd_pct, input int rcv_pct, input int count);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    repeat (count) send_shapes(random_pair());
  endtask

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    verdicts = new();
    send_idle_pct = 22;
    recv_idle_pct = 82;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // touching rectangles, then full-range rectangles
    send_shapes(shape_pair(sot_pkg::MODE_RECT_RECT, 0, 0, 0, 16, 16, 0, 16, 0, 16, 16, 0));
    send_shapes(shape_pair(sot_pkg::MODE_RECT_RECT, 1, 0, 0, 16, 16, 0, 16, 0, 16, 16, 0));
    send_shapes(shape_pair(sot_pkg::MODE_RECT_RECT, 0, -32768, -32768, 32767, 32767, 32767,
                           32767, 32767, 32767, 32767, 32767));
    // zero-size rectangles at one point
    send_shapes(shape_pair(sot_pkg::MODE_RECT_RECT, 0, 5, 5, 0, 0, 0, 5, 5, 0, 0, 0));
    send_shapes(shape_pair(sot_pkg::MODE_RECT_RECT, 1, 5, 5, 0, 0, 0, 5, 5, 0, 0, 0));
    // circle touching a rectangle corner, inclusive and strict
    send_shapes(shape_pair(sot_pkg::MODE_RECT_CIRCLE, 0, 0, 0, 48, 48, 0, -48, -64, 0, 0, 80));
    send_shapes(shape_pair(sot_pkg::MODE_RECT_CIRCLE, 1, 0, 0, 48, 48, 0, -48, -64, 0, 0, 80));
    send_shapes(shape_pair(sot_pkg::MODE_RECT_CIRCLE, 0, 0, 0, 48, 48, 0, 96, 112, 0, 0, 79));
    // circle touching a rectangle side
    send_shapes(shape_pair(sot_pkg::MODE_RECT_CIRCLE, 0, 0, 0, 64, 64, 0, 96, 32, 0, 0, 32));
    send_shapes(shape_pair(sot_pkg::MODE_RECT_CIRCLE, 1, 0, 0, 64, 64, 0, 96, 32, 0, 0, 32));
    send_shapes(shape_pair(sot_pkg::MODE_RECT_CIRCLE, 0, 0, 0, 64, 64, 0, 64, 10, 0, 0, 0));
    // touching circles, then far-apart largest circles
    send_shapes(shape_pair(sot_pkg::MODE_CIRCLE_CIRCLE, 0, 0, 0, 0, 0, 32, 48, 64, 0, 0, 48));
    send_shapes(shape_pair(sot_pkg::MODE_CIRCLE_CIRCLE, 1, 0, 0, 0, 0, 32, 48, 64, 0, 0, 48));
    send_shapes(shape_pair(sot_pkg::MODE_CIRCLE_CIRCLE, 0, -32768, -32768, 0, 0, 32767,
                           32767, 32767, 0, 0, 32767));
    // containment ignores strict
    send_shapes(shape_pair(sot_pkg::MODE_RECT_IN_RECT, 1, 10, 20, 100, 200, 0,
                           10, 20, 100, 200, 0));
    send_shapes(shape_pair(sot_pkg::MODE_RECT_IN_RECT, 0, -32768, 0, 32767, 32767, 0,
                           -32768, -32768, 32767, 32767, 0));
    send_shapes(shape_pair(sot_pkg::MODE_RECT_IN_CIRCLE, 0, 0, 0, 48, 64, 0, 0, 0, 0, 0, 80));
    send_shapes(shape_pair(sot_pkg::MODE_RECT_IN_CIRCLE, 1, 0, 0, 48, 64, 0, 0, 0, 0, 0, 79));
    send_shapes(shape_pair(sot_pkg::MODE_CIRCLE_IN_RECT, 1, 32, 32, 0, 0, 32, 0, 0, 64, 64, 0));
    send_shapes(shape_pair(sot_pkg::MODE_CIRCLE_IN_RECT, 0, 32, 32, 0, 0, 33, 0, 0, 64, 64, 0));
    // inner circle larger than the container, equal radii on one centre, then offset
    send_shapes(shape_pair(sot_pkg::MODE_CIRCLE_IN_CIRCLE, 0, 0, 0, 0, 0, 50, 0, 0, 0, 0, 40));
    send_shapes(shape_pair(sot_pkg::MODE_CIRCLE_IN_CIRCLE, 1, 7, 7, 0, 0, 40, 7, 7, 0, 0, 40));
    send_shapes(shape_pair(sot_pkg::MODE_CIRCLE_IN_CIRCLE, 0, 8, 7, 0, 0, 40, 7, 7, 0, 0, 40));
    send_shapes(shape_pair(MODE_UNDEFINED, 1, -1, -1, 32767, 32767, 32767,
                           -1, -1, 32767, 32767, 32767));

    run_phase(22, 82, 150);
    run_phase(82, 22, 150);
    run_phase(0, 0, 150);
    in_valid <= 1'b0;

    while (verdicts.awaited_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (verdicts.mismatches == 0 && verdicts.awaited_verdicts.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/sot_pkg.sv
rtl/core/sot_setup.sv
rtl/core/sot_square.sv
rtl/core/sot_decide.sv
rtl/core/shape_overlap_test_unit.sv
sim/tb.sv
